/* hw/rtl/radial_distortion_remap_macros.svh */
// assertion macros for the radial distortion remap block
// used by the port checker; needs a clock i_clk and reset i_rst_n in scope
`ifndef RADIAL_DISTORTION_REMAP_MACROS_SVH
`define RADIAL_DISTORTION_REMAP_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define RDR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion on the block clock and reset
`define RDR_ASSERT(lbl, prop, msg) `RDR_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

/* hw/rtl/rdr_pkg.sv */
// shared types and constants of the radial distortion remap block
// no dependencies
`timescale 1ns / 1ps

package rdr_pkg;

    // parameter defaults
    localparam int COORD_BITS_DEF    = 14;
    localparam int OUT_FRAC_BITS_DEF = 8;

    // port widths
    localparam int IN_W       = 14;
    localparam int COEF_W     = 24;
    localparam int NORM_W     = 32;
    localparam int CTR_W      = 13;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // fixed point formats
    localparam int QF      = 20;
    localparam int R_W     = 23;
    localparam int R2_W    = 26;
    localparam int R3_W    = 29;
    localparam int S_W     = 36;
    localparam int KT_W    = 27;
    localparam int ONE_Q   = 1 << QF;
    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    // square root: result bits per pipeline stage
    localparam int SQ_STEP = 4;
    // register stages from radius to scale
    localparam int SC_LAT  = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd5;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
        logic        [NORM_W-1:0] norm_factor;
        logic        [CTR_W-1:0]  center_x;
        logic        [CTR_W-1:0]  center_y;
        logic signed [KT_W-1:0]   kterm;      // 1 - a - b - c in Q.20
    } t_cfg;

endpackage

/* hw/rtl/rdr_cfg.sv */
// configuration register file of the radial distortion remap block
// depends on rdr_pkg
`timescale 1ns / 1ps

module rdr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [rdr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rdr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_cfg_ready,
    output rdr_pkg::t_cfg                  o_cfg
);
    import rdr_pkg::*;

    t_cfg r_cfg, n_cfg;

    // always ready for a write beat
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes, constant term is computed from the registered coefficients and follows them in the next cycle
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COEF_A:   n_cfg.coef_a      = $signed(i_cfg_data[COEF_W-1:0]);
                CFG_COEF_B:   n_cfg.coef_b      = $signed(i_cfg_data[COEF_W-1:0]);
                CFG_COEF_C:   n_cfg.coef_c      = $signed(i_cfg_data[COEF_W-1:0]);
                CFG_NORM:     n_cfg.norm_factor = i_cfg_data[NORM_W-1:0];
                CFG_CENTER_X: n_cfg.center_x    = i_cfg_data[CTR_W-1:0];
                CFG_CENTER_Y: n_cfg.center_y    = i_cfg_data[CTR_W-1:0];
                default: ;
            endcase
        end
        n_cfg.kterm = KT_W'(ONE_Q) - KT_W'($signed(r_cfg.coef_a))
                    - KT_W'($signed(r_cfg.coef_b)) - KT_W'($signed(r_cfg.coef_c));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{kterm: KT_W'(ONE_Q), default: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* hw/rtl/rdr_isqrt.sv */
// pipelined integer square root, SQ_STEP result bits per stage
// depends on rdr_pkg
`timescale 1ns / 1ps

module rdr_isqrt #(
    parameter int N_ST = 6
) (
    input  logic                                   i_clk,
    input  logic [2*N_ST*rdr_pkg::SQ_STEP-1:0]     i_rad,
    output logic [N_ST*rdr_pkg::SQ_STEP-1:0]       o_root
);
    import rdr_pkg::*;

    localparam int NS  = N_ST * SQ_STEP;
    localparam int RMW = NS + 3;

    logic [2*NS-1:0] r_rad  [N_ST];
    logic [NS-1:0]   r_root [N_ST];
    logic [RMW-1:0]  r_rem  [N_ST];

    for (genvar g = 0; g < N_ST; g++) begin : g_st
        logic [2*NS-1:0] rad_in, n_rad;
        logic [NS-1:0]   root_in, n_root;
        logic [RMW-1:0]  rem_in, n_rem;

        if (g == 0) begin : g_first
            assign rad_in  = i_rad;
            assign root_in = '0;
            assign rem_in  = '0;
        end else begin : g_next
            assign rad_in  = r_rad[g-1];
            assign root_in = r_root[g-1];
            assign rem_in  = r_rem[g-1];
        end

        // digit-by-digit root, two radicand bits per step
        always_comb begin : p_steps
            logic [RMW-1:0] acc;
            logic [RMW-1:0] trial;
            n_rad  = rad_in;
            n_root = root_in;
            n_rem  = rem_in;
            for (int i = 0; i < SQ_STEP; i++) begin
                acc   = {n_rem[RMW-3:0], n_rad[2*NS-1 -: 2]};
                trial = RMW'({n_root, 2'b01});
                n_rad = n_rad << 2;
                if (acc >= trial) begin
                    n_rem  = acc - trial;
                    n_root = {n_root[NS-2:0], 1'b1};
                end else begin
                    n_rem  = acc;
                    n_root = {n_root[NS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[g]  <= n_rad;
            r_root[g] <= n_root;
            r_rem[g]  <= n_rem;
        end
    end

    assign o_root = r_root[N_ST-1];

endmodule

/* hw/rtl/rdr_scale.sv */
// radius normalisation and cubic radial scale, six register stages
// depends on rdr_pkg
`timescale 1ns / 1ps

module rdr_scale #(
    parameter int RAD_W = 24
) (
    input  logic                           i_clk,
    input  logic [RAD_W-1:0]               i_rad,
    input  rdr_pkg::t_cfg                  i_cfg,
    output logic signed [rdr_pkg::S_W-1:0] o_s
);
    import rdr_pkg::*;

    localparam int PW  = RAD_W + NORM_W;
    localparam int PW1 = PW + 1;
    localparam logic [PW1-1:0] RND  = PW1'(1) << (QF - 1);
    localparam logic [PW1-1:0] RMAX = PW1'((1 << R_W) - 1);

    logic [PW-1:0]            r_prod;
    logic [R_W-1:0]           r_r, r_r_d1, r_r_d2;
    logic [R2_W-1:0]          r_r2, r_r2_d;
    logic [R3_W-1:0]          r_r3;
    logic signed [COEF_W+R3_W:0] r_pa;
    logic signed [COEF_W+R2_W:0] r_pb;
    logic signed [COEF_W+R_W:0]  r_pc;
    logic signed [S_W-1:0]    r_s;

    logic [PW1-1:0]           rnd_sum;
    logic [PW1-1:0]           r_full;
    logic [2*R_W-1:0]         sq;
    logic [R2_W+R_W-1:0]      cube;

    // round and clip the normalised radius below 8.0
    assign rnd_sum = PW1'(r_prod) + RND;
    assign r_full  = rnd_sum >> QF;
    assign sq      = r_r * r_r;
    assign cube    = r_r2 * r_r_d1;

    always_ff @(posedge i_clk) begin
        // radius times normalisation factor
        r_prod <= PW'(i_rad) * PW'(i_cfg.norm_factor);
        // normalised radius
        r_r    <= (r_full > RMAX) ? RMAX[R_W-1:0] : r_full[R_W-1:0];
        // square
        r_r2   <= sq[2*R_W-1:QF];
        r_r_d1 <= r_r;
        // cube
        r_r3   <= cube[R2_W+R_W-1:QF];
        r_r2_d <= r_r2;
        r_r_d2 <= r_r_d1;
        // coefficient products
        r_pa   <= $signed(i_cfg.coef_a) * $signed({1'b0, r_r3});
        r_pb   <= $signed(i_cfg.coef_b) * $signed({1'b0, r_r2_d});
        r_pc   <= $signed(i_cfg.coef_c) * $signed({1'b0, r_r_d2});
        // sum of floored terms and constant term
        r_s    <= S_W'(r_pa >>> QF) + S_W'(r_pb >>> QF) + S_W'(r_pc >>> QF)
                + S_W'(i_cfg.kterm);
    end

    assign o_s = r_s;

endmodule

/* hw/rtl/radial_distortion_remap.sv */
// top level of the radial distortion remap block
// depends on rdr_pkg, rdr_cfg, rdr_isqrt, rdr_scale
`timescale 1ns / 1ps

// Maps each destination pixel (column,row) to a source position for a cubic radial
// lens model. One pixel is taken in every clock: o_busy is always low, so a beat on
// i_start is accepted whenever it is high. Each result appears as a one-cycle o_valid
// strobe; the receiver cannot stall it. The result passes through the square root
// pipeline (SQ_STEP root bits per stage) followed by the six-stage radius/scale
// multiplier chain. The user must write configuration through the cfg port only while
// no pixel is in flight; the block itself does not enforce this.
module radial_distortion_remap #(
    parameter int COORD_BITS    = rdr_pkg::COORD_BITS_DEF,
    parameter int OUT_FRAC_BITS = rdr_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [rdr_pkg::IN_W-1:0]       i_column,
    input  logic [rdr_pkg::IN_W-1:0]       i_row,
    output logic                           o_valid,
    output logic signed [rdr_pkg::OUT_W-1:0] o_source_x,
    output logic signed [rdr_pkg::OUT_W-1:0] o_source_y,
    output logic                           o_saturated,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rdr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rdr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rdr_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int DW    = ((CW > CTR_W) ? CW : CTR_W) + 1;
    localparam int D2W   = 2 * DW;
    localparam int SQ_ST = (DW + 8 + SQ_STEP - 1) / SQ_STEP;
    localparam int NS    = SQ_ST * SQ_STEP;
    localparam int DL    = SQ_ST + SC_LAT + 1;
    localparam int LAT   = SQ_ST + 10;
    localparam int K     = QF - OUT_FRAC_BITS;
    localparam int MW    = DW + S_W;
    localparam int PW    = MW + 1;
    localparam logic signed [PW-1:0] RND  = PW'(64'sd1 << (K - 1));
    localparam logic signed [PW-1:0] OMAX = PW'(OUT_MAX);
    localparam logic signed [PW-1:0] OMIN = PW'(OUT_MIN);

    t_cfg cfg;

    logic [CW-1:0]          col_m, row_m;
    logic                   r1_vld;
    logic signed [DW-1:0]   r1_dx, r1_dy;
    logic [D2W-1:0]         r_d2;
    logic [D2W-1:0]         sqx, sqy;
    logic [2*NS-1:0]        rad_in;
    logic [NS-1:0]          root;
    logic signed [S_W-1:0]  s;
    logic                   r_vld_d [DL];
    logic signed [DW-1:0]   r_dx_d  [DL];
    logic signed [DW-1:0]   r_dy_d  [DL];
    logic                   r_px_vld;
    logic signed [MW-1:0]   r_px, r_py;
    logic                   r_out_vld;
    logic signed [OUT_W-1:0] r_src_x, r_src_y;
    logic                   r_sat;
    logic signed [PW-1:0]   vx, vy;
    logic [OUT_W-1:0]       n_src_x, n_src_y;
    logic                   n_sat;

    assign o_busy = 1'b0;

    rdr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // offsets from the centre on the accepted beat
    assign col_m = CW'(i_column);
    assign row_m = CW'(i_row);

    always_ff @(posedge i_clk) begin
        r1_dx <= $signed(DW'(col_m)) - $signed(DW'(cfg.center_x));
        r1_dy <= $signed(DW'(row_m)) - $signed(DW'(cfg.center_y));
    end

    // squared distance
    assign sqx = unsigned'(D2W'(r1_dx) * D2W'(r1_dx));
    assign sqy = unsigned'(D2W'(r1_dy) * D2W'(r1_dy));

    always_ff @(posedge i_clk) begin
        r_d2 <= sqx + sqy;
    end

    // squared distance with sixteen fraction bits, giving a radius with eight fraction bits
    assign rad_in = (2*NS)'(r_d2) << 16;

    rdr_isqrt #(.N_ST(SQ_ST)) u_isqrt (
        .i_clk  (i_clk),
        .i_rad  (rad_in),
        .o_root (root)
    );

    rdr_scale #(.RAD_W(NS)) u_scale (
        .i_clk (i_clk),
        .i_rad (root),
        .i_cfg (cfg),
        .o_s   (s)
    );

    // offsets and valid bits travel alongside the root and scale stages
    always_ff @(posedge i_clk) begin
        r_dx_d[0] <= r1_dx;
        r_dy_d[0] <= r1_dy;
        for (int i = 1; i < DL; i++) begin
            r_dx_d[i] <= r_dx_d[i-1];
            r_dy_d[i] <= r_dy_d[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r_px_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < DL; i++) begin
                r_vld_d[i] <= 1'b0;
            end
        end else begin
            r1_vld     <= i_start;
            r_vld_d[0] <= r1_vld;
            for (int i = 1; i < DL; i++) begin
                r_vld_d[i] <= r_vld_d[i-1];
            end
            r_px_vld  <= r_vld_d[DL-1];
            r_out_vld <= r_px_vld;
        end
    end

    // offset times scale
    always_ff @(posedge i_clk) begin
        r_px <= r_dx_d[DL-1] * s;
        r_py <= r_dy_d[DL-1] * s;
    end

    // round to output format, add centre, clip
    always_comb begin
        vx = ((PW'(r_px) + RND) >>> K)
           + (PW'($signed({1'b0, cfg.center_x})) <<< OUT_FRAC_BITS);
        vy = ((PW'(r_py) + RND) >>> K)
           + (PW'($signed({1'b0, cfg.center_y})) <<< OUT_FRAC_BITS);
        n_sat = 1'b0;
        if (vx > OMAX) begin
            n_src_x = OMAX[OUT_W-1:0];
            n_sat   = 1'b1;
        end else if (vx < OMIN) begin
            n_src_x = OMIN[OUT_W-1:0];
            n_sat   = 1'b1;
        end else begin
            n_src_x = vx[OUT_W-1:0];
        end
        if (vy > OMAX) begin
            n_src_y = OMAX[OUT_W-1:0];
            n_sat   = 1'b1;
        end else if (vy < OMIN) begin
            n_src_y = OMIN[OUT_W-1:0];
            n_sat   = 1'b1;
        end else begin
            n_src_y = vy[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_src_x <= $signed(n_src_x);
        r_src_y <= $signed(n_src_y);
        r_sat   <= n_sat;
    end

    assign o_valid     = r_out_vld;
    assign o_source_x  = r_src_x;
    assign o_source_y  = r_src_y;
    assign o_saturated = r_sat;

endmodule

/* hw/rtl/rdr_checker.sv */
// port checker for the radial distortion remap block, bound to the top level
// depends on radial_distortion_remap_macros.svh and radial_distortion_remap
`timescale 1ns / 1ps
`include "radial_distortion_remap_macros.svh"

module rdr_checker #(
    parameter int LAT = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_start,
    input logic                           o_busy,
    input logic                           o_valid,
    input logic signed [rdr_pkg::OUT_W-1:0] o_source_x,
    input logic signed [rdr_pkg::OUT_W-1:0] o_source_y,
    input logic                           o_saturated
);
    import rdr_pkg::*;

    // every accepted beat yields a result after the fixed latency
    `RDR_ASSERT(a_beat_to_result, (i_start && !o_busy) |-> ##LAT o_valid, "result missing")
    // no result without a beat accepted the fixed latency earlier
    `RDR_ASSERT(a_result_from_beat, o_valid |-> $past(i_start && !o_busy, LAT), "spurious result")
    // a saturated result sits at a range limit
    `RDR_ASSERT(a_sat_at_limit, (o_valid && o_saturated) |-> (o_source_x == OUT_W'(OUT_MAX) || o_source_x == OUT_W'(OUT_MIN) || o_source_y == OUT_W'(OUT_MAX) || o_source_y == OUT_W'(OUT_MIN)), "saturation flag without clipped coordinate")

endmodule

bind radial_distortion_remap rdr_checker #(.LAT(LAT)) u_rdr_checker (.*);
